/* rtl/core/cse_pkg.sv */
// Shared types and codes for the counting sort engine.
package cse_pkg;

  // Input command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SPAN = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned SPAN_W     = 11;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 11'd1024;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] value;
  } cse_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      valid_res;
    logic                      out_of_range;
    logic                      done_res;
  } cse_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_UPD,
    ST_SCAN,
    ST_RESP_OOR,
    ST_RESP_EMPTY
  } cse_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;     // write zero at clear counter, advance
    logic add_start;    // read bucket of incoming value
    logic take_start;   // read bucket at scan position
    logic scan_step;    // read next bucket of the scan
    logic add_commit;   // bump bucket (or flag saturation), load result
    logic take_commit;  // decrement hit bucket, load result
    logic resp_oor;     // load out-of-range result
    logic resp_empty;   // load empty-take result
  } cse_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic cmd_take;     // incoming beat is a take
    logic in_range;     // incoming value maps to a bucket in span
    logic rem_zero;     // no counted values held
    logic hit;          // registered bucket read is non-zero
    logic clr_last;     // clear counter at last bucket
    logic out_free;     // result register can be loaded this cycle
  } cse_stat_t;

endpackage

/* rtl/core/cse_ctrl.sv */
// Sequencer for clearing, add and take operations of the counting sort engine.
module cse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cse_pkg::cse_stat_t stat_i,
  output cse_pkg::cse_ctrl_t ctrl_o
);

  cse_pkg::cse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cse_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl_o    = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      cse_pkg::ST_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_nxt = cse_pkg::ST_IDLE;
        end
      end
      cse_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat_i.cmd_take) begin
            if (stat_i.rem_zero) begin
              state_nxt = cse_pkg::ST_RESP_EMPTY;
            end else begin
              ctrl_o.take_start = 1'b1;
              state_nxt         = cse_pkg::ST_SCAN;
            end
          end else if (stat_i.in_range) begin
            ctrl_o.add_start = 1'b1;
            state_nxt        = cse_pkg::ST_ADD_UPD;
          end else begin
            state_nxt = cse_pkg::ST_RESP_OOR;
          end
        end
      end
      cse_pkg::ST_ADD_UPD: begin
        if (stat_i.out_free) begin
          ctrl_o.add_commit = 1'b1;
          state_nxt         = cse_pkg::ST_IDLE;
        end
      end
      cse_pkg::ST_SCAN: begin
        // Hit data stays in the read register while the result slot is busy.
        if (stat_i.hit) begin
          if (stat_i.out_free) begin
            ctrl_o.take_commit = 1'b1;
            state_nxt          = cse_pkg::ST_IDLE;
          end
        end else begin
          ctrl_o.scan_step = 1'b1;
        end
      end
      cse_pkg::ST_RESP_OOR: begin
        if (stat_i.out_free) begin
          ctrl_o.resp_oor = 1'b1;
          state_nxt       = cse_pkg::ST_IDLE;
        end
      end
      cse_pkg::ST_RESP_EMPTY: begin
        if (stat_i.out_free) begin
          ctrl_o.resp_empty = 1'b1;
          state_nxt         = cse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/cse_datapath.sv */
// Bucket store, counters, configuration and result register of the counting sort engine.
module cse_datapath #(
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cse_pkg::cse_in_t                    in_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output cse_pkg::cse_out_t                   out_data,
  input  logic                                cfg_wr_en,
  input  logic [cse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cse_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  cse_pkg::cse_ctrl_t                  ctrl_i,
  output cse_pkg::cse_stat_t                  stat_o
);

  localparam int unsigned IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned REM_W = IDX_W + COUNT_BITS;
  localparam int unsigned DIFF_W = cse_pkg::VALUE_W + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BUCKETS - 1);
  localparam logic [DIFF_W-1:0] BUCKETS_L = DIFF_W'(BUCKETS);

  // Configuration
  logic signed [cse_pkg::VALUE_W-1:0] base_r;
  logic [cse_pkg::SPAN_W-1:0]         span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      span_r <= cse_pkg::SPAN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cse_pkg::REG_VALUE_BASE:  base_r <= cfg_wdata;
        cse_pkg::REG_BUCKET_SPAN: span_r <= cfg_wdata[cse_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Bucket index of the incoming value
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] mag;
  logic              in_range;

  assign diff = {in_data.value[cse_pkg::VALUE_W-1], in_data.value}
              - {base_r[cse_pkg::VALUE_W-1], base_r};
  assign mag  = {1'b0, diff[cse_pkg::VALUE_W-1:0]};
  assign in_range = !diff[DIFF_W-1]
                 && (mag < DIFF_W'(span_r))
                 && (mag < BUCKETS_L);

  // Control registers
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] scan_pos_r;
  logic [IDX_W-1:0] scan_addr_r;
  logic [REM_W-1:0] rem_r;

  // Bucket store and its registered read
  logic [COUNT_BITS-1:0] counts [BUCKETS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  sat;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
    next_idx = (a == LAST_IDX) ? '0 : a + IDX_W'(1);
  endfunction

  assign sat   = &rd_data_r;
  assign rd_en = ctrl_i.add_start | ctrl_i.take_start | ctrl_i.scan_step;

  always_comb begin
    rd_addr = scan_addr_r;
    if (ctrl_i.add_start) begin
      rd_addr = diff[IDX_W-1:0];
    end else if (ctrl_i.take_start) begin
      rd_addr = scan_pos_r;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_r;
    wr_data = rd_data_r;
    if (ctrl_i.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (ctrl_i.add_commit) begin
      wr_en   = !sat;
      wr_data = rd_data_r + COUNT_BITS'(1);
    end else if (ctrl_i.take_commit) begin
      wr_en   = 1'b1;
      wr_data = rd_data_r - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      counts[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= counts[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Remaining count and scan position
  logic [REM_W-1:0] rem_nxt;
  logic [REM_W-1:0] rem_dec;

  assign rem_dec = rem_r - REM_W'(1);

  always_comb begin
    rem_nxt = rem_r;
    if (ctrl_i.add_commit && !sat) begin
      rem_nxt = rem_r + REM_W'(1);
    end else if (ctrl_i.take_commit) begin
      rem_nxt = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      scan_pos_r <= '0;
      rem_r      <= '0;
    end else begin
      rem_r <= rem_nxt;
      if (ctrl_i.clr_step) begin
        clr_cnt_r <= next_idx(clr_cnt_r);
      end
      if (ctrl_i.take_commit) begin
        scan_pos_r <= (rem_dec == '0) ? '0 : rd_addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.take_start) begin
      scan_addr_r <= next_idx(scan_pos_r);
    end else if (ctrl_i.scan_step) begin
      scan_addr_r <= next_idx(scan_addr_r);
    end
  end

  // Result register
  logic              out_valid_r;
  cse_pkg::cse_out_t out_r;
  logic              out_load;
  cse_pkg::cse_out_t out_nxt;

  assign out_load = ctrl_i.add_commit | ctrl_i.take_commit
                  | ctrl_i.resp_oor | ctrl_i.resp_empty;

  always_comb begin
    out_nxt              = '0;
    out_nxt.done_res     = (rem_nxt == '0);
    if (ctrl_i.take_commit) begin
      out_nxt.sorted_value = $unsigned(base_r) + cse_pkg::VALUE_W'(rd_addr_r);
      out_nxt.valid_res    = 1'b1;
    end else if (ctrl_i.add_commit) begin
      out_nxt.out_of_range = sat;
    end else if (ctrl_i.resp_oor) begin
      out_nxt.out_of_range = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat_o.cmd_take = (in_data.command == cse_pkg::CMD_TAKE);
  assign stat_o.in_range = in_range;
  assign stat_o.rem_zero = (rem_r == '0);
  assign stat_o.hit      = (rd_data_r != '0);
  assign stat_o.clr_last = (clr_cnt_r == LAST_IDX);
  assign stat_o.out_free = !out_valid_r || out_ready;

endmodule

/* rtl/core/counting_sort_engine_core.sv */
// Top level of the counting sort engine: controller plus bucket datapath.
//
//  channel  | ports                          | dir | beat
//  ---------+--------------------------------+-----+-----------------------------------
//  in       | in_valid, in_ready, in_data    | in  | command + value (cse_in_t)
//  out      | out_valid, out_ready, out_data | out | one result per input beat
//  cfg      | cfg_wr_en, cfg_index, cfg_wdata| in  | 0 = value_base, 1 = bucket_span
//
//  Add: accept, then read-modify-write of the bucket store.
//  Take: the scan passes over empty buckets and reads one bucket per
//  cycle from the single read port of the bucket store.
//  Reset: a clearing pass writes zero to all BUCKETS entries;
//  in_ready stays low meanwhile, configuration writes are taken at any time.
//  Stalls: the result register holds a beat while out_ready is low; the next
//  input beat is still accepted and waits only at its own result load.
module counting_sort_engine_core #(
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cse_pkg::cse_in_t               in_data,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output cse_pkg::cse_out_t              out_data,
  // Configuration port
  input  logic                           cfg_wr_en,
  input  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cse_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cse_pkg::cse_ctrl_t ctrl;
  cse_pkg::cse_stat_t stat;

  // Sequencer: clear pass, add, scan and result load decisions
  cse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .ctrl_o   (ctrl)
  );

  // Bucket store, totals, scan pointer, registers and result register
  cse_datapath #(
    .BUCKETS    (BUCKETS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctrl_i    (ctrl),
    .stat_o    (stat)
  );

endmodule

/* tb/sv/tb_counting_sort_engine_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for counting_sort_engine_core: directed, repeat-bucket, random and drain.
module tb_counting_sort_engine_core;
  import cse_pkg::*;

  localparam int BUCKETS      = 1024;
  localparam int COUNT_BITS   = 16;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  // Worst case: every take scans all buckets, plus gaps, stalls and the clear pass.
  localparam longint LIMIT_CYCLES = 64'd6_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cse_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cse_out_t out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  counting_sort_engine_core #(
    .BUCKETS    (BUCKETS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the engine: histogram, scan pointer, live total and registers
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] hist [BUCKETS];
  int                    scan_pos = 0;
  longint                live_total = 0;
  logic signed [15:0]    base_r = 16'sd0;
  logic [SPAN_W-1:0]     span_r = SPAN_RESET;

  initial begin
    for (int i = 0; i < BUCKETS; i++) hist[i] = '0;
  end

  // Commands waiting for the driver, results waiting for the monitor
  cse_in_t  cmd_q[$];
  cse_out_t sorted_q[$];

  int  send_idle_pct = 0;  // chance per cycle that the driver holds off
  int  stall_pct = 0;      // chance per cycle that out_ready is low
  logic in_beat_taken = 1'b0;
  int  n_pushed = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_flagged = 0;
  int  n_empty = 0;
  int  n_settings = 0;
  int  fails = 0;
  longint cycles = 0;

  // Apply one command beat to the shadow histogram and return the result beat.
  function automatic cse_out_t count_and_take(cse_in_t beat);
    cse_out_t r;
    int       idx;
    int       span_eff;
    int       pos;
    int       n;
    r = '0;
    if (beat.command == CMD_ADD) begin
      idx = int'($signed(beat.value)) - int'(base_r);
      span_eff = (int'(span_r) > BUCKETS) ? BUCKETS : int'(span_r);
      if (idx < 0 || idx >= span_eff) begin
        r.out_of_range = 1'b1;
      end else if (int'(hist[idx]) >= COUNT_MAX) begin
        r.out_of_range = 1'b1;   // bucket full, add dropped
      end else begin
        hist[idx]++;
        live_total++;
      end
    end else if (live_total != 0) begin
      // Scan upward from the pointer, wrapping past the last bucket.
      pos = (scan_pos < BUCKETS) ? scan_pos : 0;
      n = 0;
      while (n < BUCKETS && hist[pos] == '0) begin
        pos = (pos + 1 < BUCKETS) ? pos + 1 : 0;
        n++;
      end
      if (n < BUCKETS) begin
        hist[pos]--;
        live_total--;
        r.sorted_value = base_r + 16'(pos);
        r.valid_res = 1'b1;
        scan_pos = (live_total == 0) ? 0 : pos;
      end
    end
    r.done_res = (live_total == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands on the falling edge, holds until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result beats, then predict for the accepted command beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cse_out_t want;
    in_beat_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        $error("result beat with no command outstanding: %p", out_data);
        fails++;
      end else begin
        want = sorted_q.pop_front();
        n_checked++;
        if (want.out_of_range) n_flagged++;
        if (!want.valid_res && !want.out_of_range && want.done_res) n_empty++;
        if (out_data.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 out_data.sorted_value);
          fails++;
        end
        if (out_data.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0b, got %0b", want.valid_res, out_data.valid_res);
          fails++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                 out_data.out_of_range);
          fails++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res: expected %0b, got %0b", want.done_res, out_data.done_res);
          fails++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      sorted_q.push_back(count_and_take(in_data));
      n_accepted++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void put(input logic cmd, input logic [15:0] v);
    cse_in_t b;
    b.command = cmd;
    b.value = v;
    cmd_q.push_back(b);
    n_pushed++;
  endfunction

  // Register write; only called with no command outstanding, so the shadow updates at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_VALUE_BASE) base_r = data;
    else span_r = data[SPAN_W-1:0];
    n_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every command is accepted and every result has come back.
  task automatic settle();
    do @(negedge clk);
    while (n_accepted != n_pushed || sorted_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Mostly values inside the span, some just outside, some anywhere.
  function automatic logic [15:0] pick_value();
    int b;
    int span_eff;
    int hi;
    int sel;
    b = base_r;
    span_eff = (int'(span_r) > BUCKETS) ? BUCKETS : int'(span_r);
    hi = 32767 - b;
    if (span_eff - 1 < hi) hi = span_eff - 1;
    sel = $urandom_range(0, 99);
    if (sel < 70 && hi >= 0) return 16'(b + int'($urandom_range(0, hi)));
    if (sel < 85) return $urandom_range(0, 1) ? 16'(b - 1) : 16'(b + span_eff);
    return 16'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    int left;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Registers may be written during the clearing pass.
    write_reg(REG_VALUE_BASE, 16'd0);
    write_reg(REG_BUCKET_SPAN, 16'd1024);

    // Span edges, dropped adds, wrap of the scan past the last bucket.
    put(CMD_TAKE, 16'hFFFF);             // take with nothing held
    put(CMD_ADD, 16'd0);
    put(CMD_ADD, 16'd1023);              // top bucket
    put(CMD_ADD, 16'd1024);              // one past the span
    put(CMD_ADD, 16'hFFFF);              // one below base
    put(CMD_ADD, 16'h7FFF);
    put(CMD_ADD, 16'h8000);
    put(CMD_ADD, 16'd5);
    put(CMD_TAKE, 16'd0);
    put(CMD_TAKE, 16'd0);                // pointer now at bucket 5
    put(CMD_ADD, 16'd2);                 // lands below the pointer
    put(CMD_TAKE, 16'd0);
    put(CMD_TAKE, 16'd0);                // wraps around to bucket 2
    put(CMD_TAKE, 16'd0);
    settle();

    // Most negative base, span above the bucket count.
    write_reg(REG_VALUE_BASE, 16'h8000);
    write_reg(REG_BUCKET_SPAN, 16'd2047);
    put(CMD_ADD, 16'h8000);
    put(CMD_ADD, 16'h83FF);
    put(CMD_ADD, 16'h8400);              // clipped to 1024 buckets
    put(CMD_ADD, 16'h7FFF);
    put(CMD_TAKE, 16'd0);
    put(CMD_TAKE, 16'd0);
    settle();

    // Registers changed with a count held: wide result wraps, zero span drains.
    write_reg(REG_VALUE_BASE, 16'd0);
    write_reg(REG_BUCKET_SPAN, 16'd1024);
    put(CMD_ADD, 16'd1000);
    settle();
    write_reg(REG_VALUE_BASE, 16'h7FFF);
    write_reg(REG_BUCKET_SPAN, 16'd0);
    put(CMD_ADD, 16'h7FFF);              // zero span rejects everything
    put(CMD_TAKE, 16'd0);
    settle();
    write_reg(REG_BUCKET_SPAN, 16'd1);
    put(CMD_ADD, 16'h7FFF);
    put(CMD_TAKE, 16'd0);
    settle();

    // Several beats into one bucket, then drain it plus one take on empty.
    write_reg(REG_VALUE_BASE, 16'hFFFB);
    write_reg(REG_BUCKET_SPAN, 16'd16);
    for (k = 0; k < 8; k++) put(CMD_ADD, 16'd3);
    for (k = 0; k <= 8; k++) put(CMD_TAKE, 16'(k));
    settle();

    // Random phases; counts carry over between register settings.
    for (int p = 0; p < 8; p++) begin
      send_idle_pct = (p % 4 == 1) ? 62 : (p % 4 == 3) ? 22 : 0;
      stall_pct     = (p % 4 == 2) ? 62 : (p % 4 == 3) ? 22 : 0;
      case (p)
        0: begin
          write_reg(REG_VALUE_BASE, 16'h8000);
          write_reg(REG_BUCKET_SPAN, 16'd1024);
        end
        1: begin
          write_reg(REG_VALUE_BASE, 16'h7FFF);
          write_reg(REG_BUCKET_SPAN, 16'd2047);
        end
        2: begin
          write_reg(REG_VALUE_BASE, 16'($urandom()));
          write_reg(REG_BUCKET_SPAN, 16'd2);
        end
        3: begin
          write_reg(REG_VALUE_BASE, 16'd0);
          write_reg(REG_BUCKET_SPAN, 16'd1);
        end
        4: begin
          write_reg(REG_VALUE_BASE, 16'($urandom()));
          write_reg(REG_BUCKET_SPAN, 16'd0);
        end
        5: begin
          write_reg(REG_VALUE_BASE, 16'hFF9C);
          write_reg(REG_BUCKET_SPAN, 16'($urandom_range(3, 64)));
        end
        6: begin
          write_reg(REG_VALUE_BASE, 16'($urandom()));
          write_reg(REG_BUCKET_SPAN, 16'($urandom_range(1, 1024)));
        end
        default: begin
          write_reg(REG_VALUE_BASE, 16'($urandom()));
          write_reg(REG_BUCKET_SPAN, 16'($urandom_range(65, 2047)));
        end
      endcase
      for (k = 0; k < 110; k++) begin
        if ($urandom_range(0, 99) < 38) put(CMD_TAKE, 16'($urandom()));
        else put(CMD_ADD, pick_value());
      end
      settle();
    end

    // Drain everything still held, plus one take on the empty store.
    send_idle_pct = 22;
    stall_pct = 22;
    left = int'(live_total);
    for (k = 0; k <= left; k++) put(CMD_TAKE, 16'($urandom()));
    settle();
    repeat (16) @(negedge clk);

    $display("summary: %0d commands, %0d results checked, %0d register writes",
             n_pushed, n_checked, n_settings);
    $display("summary: %0d adds flagged out of range, %0d takes on an empty store",
             n_flagged, n_empty);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
